// ===== src/tce_pkg.sv =====
// ---------------------------------------------------------------------------
// tce_pkg
// shared types and constants of the text console engine
// ---------------------------------------------------------------------------
package tce_pkg;

   localparam int FUNC_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;
   localparam int DATA_W   = 16;
   localparam int ATTR_W   = 8;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 3;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   localparam int TAB_STEP = 8;

   localparam logic [DATA_W-1:0] RESET_BLANK      = 16'h0F20;
   localparam logic [ATTR_W-1:0] RESET_TEXT_ATTR  = 8'h04;
   localparam logic [ATTR_W-1:0] RESET_BLANK_ATTR = 8'h0F;

   localparam logic REG_TEXT_ATTR  = 1'b0;
   localparam logic REG_BLANK_ATTR = 1'b1;

   typedef enum logic [2:0] {
      OP_PRINT,
      OP_BACKSPACE,
      OP_TAB,
      OP_NEWLINE,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [INDEX_W-1:0]  cell_index;
   } cmd_type;

   typedef struct packed {
      logic [ATTR_W-1:0] text_attr;
      logic [ATTR_W-1:0] blank_attr;
   } cfg_type;

   typedef struct packed {
      logic init_busy;
   } status_type;

endpackage

// ===== src/tce_ram.sv =====
// ---------------------------------------------------------------------------
// tce_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module tce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tce_front.sv =====
// ---------------------------------------------------------------------------
// tce_front
// accepts request words, decodes them into commands and queues them
// ---------------------------------------------------------------------------
module tce_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tce_pkg::FUNC_W-1:0]   req_func,
   input  logic [tce_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tce_pkg::INDEX_W-1:0]  req_cell_index,
   input  tce_pkg::status_type          status,
   output logic                         cmd_valid,
   output tce_pkg::cmd_type             cmd,
   input  logic                         cmd_pop
);

   localparam int QDEPTH = 2;

   tce_pkg::cmd_type entry_ff [QDEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   tce_pkg::cmd_type decoded;
   logic             push;
   logic             pop;

   always_comb begin
      decoded.char_code  = req_char_code;
      decoded.cell_index = req_cell_index;
      case (req_func)
         tce_pkg::FUNC_PUT: begin
            case (req_char_code)
               tce_pkg::CHAR_BACKSPACE: decoded.op = tce_pkg::OP_BACKSPACE;
               tce_pkg::CHAR_TAB:       decoded.op = tce_pkg::OP_TAB;
               tce_pkg::CHAR_NEWLINE:   decoded.op = tce_pkg::OP_NEWLINE;
               default:                 decoded.op = tce_pkg::OP_PRINT;
            endcase
         end
         tce_pkg::FUNC_CLEAR: decoded.op = tce_pkg::OP_CLEAR;
         tce_pkg::FUNC_READ:  decoded.op = tce_pkg::OP_READ;
         default:             decoded.op = tce_pkg::OP_NOP;
      endcase
   end

   assign req_stall = (count_ff == 2'(QDEPTH)) || status.init_busy;
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== src/tce_back.sv =====
// ---------------------------------------------------------------------------
// tce_back
// executes console commands on the cell buffer and drives the response word
// ---------------------------------------------------------------------------
module tce_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tce_pkg::cfg_type              cfg,
   input  logic                          cmd_valid,
   input  tce_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output tce_pkg::status_type           status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tce_pkg::CURSOR_W-1:0]  rsp_cursor_pos,
   output logic [tce_pkg::DATA_W-1:0]    rsp_cell_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_A = ADDR_W'(CELLS - COLUMNS);
   localparam logic [COL_W:0]    COLS_C     = (COL_W + 1)'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_RESP
   } state_type;

   state_type                     state_ff;
   logic [COL_W-1:0]              col_ff;
   logic [ROW_W-1:0]              row_ff;
   logic [ADDR_W-1:0]             cnt_ff;
   logic                          pend_wr_ff;
   logic [ADDR_W-1:0]             pend_addr_ff;
   logic                          in_range_ff;
   logic [tce_pkg::DATA_W-1:0]    res_data_ff;
   logic                          rsp_valid_ff;
   logic [tce_pkg::CURSOR_W-1:0]  rsp_cursor_ff;
   logic [tce_pkg::DATA_W-1:0]    rsp_data_ff;

   logic [ADDR_W-1:0]             cur_pos;
   logic [ADDR_W-1:0]             bs_pos;
   logic [COL_W-1:0]              bs_col;
   logic [ROW_W-1:0]              bs_row;
   logic [COL_W:0]                tab_sum;
   logic                          tab_wrap;
   logic                          col_last;
   logic                          row_last;
   logic                          in_range;
   logic                          rsp_free;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [tce_pkg::DATA_W-1:0]    wr_data;
   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;
   logic [tce_pkg::DATA_W-1:0]    rd_data;

   tce_ram #(
      .WIDTH (tce_pkg::DATA_W),
      .DEPTH (CELLS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      cur_pos  = ADDR_W'(row_ff) * COLS_A + ADDR_W'(col_ff);
      col_last = (col_ff == LAST_COL);
      row_last = (row_ff == LAST_ROW);
      if (col_ff == '0) begin
         if (row_ff != '0) begin
            bs_col = LAST_COL;
            bs_row = row_ff - 1'b1;
         end else begin
            bs_col = '0;
            bs_row = '0;
         end
      end else begin
         bs_col = col_ff - 1'b1;
         bs_row = row_ff;
      end
      bs_pos   = ADDR_W'(bs_row) * COLS_A + ADDR_W'(bs_col);
      tab_sum  = {1'b0, col_ff} + (COL_W + 1)'(tce_pkg::TAB_STEP);
      tab_wrap = (tab_sum >= COLS_C);
      in_range = (int'(cmd.cell_index) < CELLS);
      rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   // buffer port steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = tce_pkg::RESET_BLANK;
      rd_en   = 1'b0;
      rd_addr = cnt_ff;
      cmd_pop = 1'b0;
      case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  tce_pkg::OP_PRINT: begin
                     wr_en   = 1'b1;
                     wr_addr = cur_pos;
                     wr_data = {cfg.text_attr, cmd.char_code};
                  end
                  tce_pkg::OP_BACKSPACE: begin
                     wr_en   = 1'b1;
                     wr_addr = bs_pos;
                     wr_data = {cfg.text_attr, tce_pkg::CHAR_SPACE};
                  end
                  tce_pkg::OP_READ: begin
                     rd_en   = in_range;
                     rd_addr = ADDR_W'(cmd.cell_index);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            rd_en   = 1'b1;
            wr_en   = pend_wr_ff;
            wr_addr = pend_addr_ff;
            wr_data = rd_data;
         end
         ST_DRAIN: begin
            wr_en   = pend_wr_ff;
            wr_addr = pend_addr_ff;
            wr_data = rd_data;
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = {cfg.blank_attr, tce_pkg::CHAR_SPACE};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         pend_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_CELL) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  res_data_ff <= '0;
                  state_ff    <= ST_RESP;
                  case (cmd.op)
                     tce_pkg::OP_PRINT: begin
                        if (col_last) begin
                           col_ff <= '0;
                           if (row_last) begin
                              cnt_ff   <= COLS_A;
                              state_ff <= ST_COPY;
                           end else begin
                              row_ff <= row_ff + 1'b1;
                           end
                        end else begin
                           col_ff <= col_ff + 1'b1;
                        end
                     end
                     tce_pkg::OP_BACKSPACE: begin
                        col_ff <= bs_col;
                        row_ff <= bs_row;
                     end
                     tce_pkg::OP_TAB: begin
                        if (tab_wrap) begin
                           if (row_last) begin
                              col_ff   <= '0;
                              cnt_ff   <= COLS_A;
                              state_ff <= ST_COPY;
                           end else begin
                              col_ff <= COL_W'(tab_sum - COLS_C);
                              row_ff <= row_ff + 1'b1;
                           end
                        end else begin
                           col_ff <= COL_W'(tab_sum);
                        end
                     end
                     tce_pkg::OP_NEWLINE: begin
                        col_ff <= '0;
                        if (row_last) begin
                           cnt_ff   <= COLS_A;
                           state_ff <= ST_COPY;
                        end else begin
                           row_ff <= row_ff + 1'b1;
                        end
                     end
                     tce_pkg::OP_CLEAR: begin
                        col_ff   <= '0;
                        row_ff   <= '0;
                        cnt_ff   <= '0;
                        state_ff <= ST_FILL;
                     end
                     tce_pkg::OP_READ: begin
                        in_range_ff <= in_range;
                        state_ff    <= ST_READ;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_READ: begin
               res_data_ff <= in_range_ff ? rd_data : '0;
               state_ff    <= ST_RESP;
            end
            // scroll: move rows up one cell per cycle
            ST_COPY: begin
               pend_wr_ff   <= 1'b1;
               pend_addr_ff <= cnt_ff - COLS_A;
               cnt_ff       <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_CELL) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               pend_wr_ff <= 1'b0;
               cnt_ff     <= LAST_ROW_A;
               state_ff   <= ST_FILL;
            end
            ST_FILL: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_CELL) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_cursor_ff <= tce_pkg::CURSOR_W'(cur_pos);
                  rsp_data_ff   <= res_data_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status.init_busy = (state_ff == ST_INIT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_pos   = rsp_cursor_ff;
   assign rsp_cell_data    = rsp_data_ff;

endmodule

// ===== src/text_console_engine_unit.sv =====
// ---------------------------------------------------------------------------
// text_console_engine_unit
// character-cell text console with cursor, scroll, clear and cell read
//
// channel  dir  handshake               payload
// req      in   req_valid / req_stall   req_func, req_char_code, req_cell_index
// rsp      out  rsp_valid / rsp_stall   rsp_cursor_pos, rsp_cell_data
// csr      in   psel/penable/pready     paddr, pwdata, prdata (apb, 2 registers)
//
// put commands without a scroll pass the idle and resp states in the executor; read passes idle, read, resp
// scroll copies the rows up through the buffer ram port (copy, drain), then blanks the last row (fill)
// clear writes one cell per cycle in the fill state
// after reset an init pass blanks the buffer, req_stall held high
// a two-word command queue keeps accepting while the executor or rsp stalls, until it is full
// ---------------------------------------------------------------------------
module text_console_engine_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tce_pkg::FUNC_W-1:0]    req_func,
   input  logic [tce_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tce_pkg::INDEX_W-1:0]   req_cell_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tce_pkg::CURSOR_W-1:0]  rsp_cursor_pos,
   output logic [tce_pkg::DATA_W-1:0]    rsp_cell_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tce_pkg::PADDR_W-1:0]   paddr,
   input  logic [tce_pkg::CSR_W-1:0]     pwdata,
   output logic [tce_pkg::CSR_W-1:0]     prdata,
   output logic                          pready
);

   logic [tce_pkg::ATTR_W-1:0] text_attr_ff;
   logic [tce_pkg::ATTR_W-1:0] blank_attr_ff;
   logic                       csr_wr;
   tce_pkg::cfg_type           cfg;
   tce_pkg::status_type        status;
   tce_pkg::cmd_type           cmd;
   logic                       cmd_valid;
   logic                       cmd_pop;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff  <= tce_pkg::RESET_TEXT_ATTR;
         blank_attr_ff <= tce_pkg::RESET_BLANK_ATTR;
      end else if (csr_wr) begin
         case (paddr[2])
            tce_pkg::REG_TEXT_ATTR:  text_attr_ff  <= pwdata[tce_pkg::ATTR_W-1:0];
            tce_pkg::REG_BLANK_ATTR: blank_attr_ff <= pwdata[tce_pkg::ATTR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         tce_pkg::REG_TEXT_ATTR:  prdata = tce_pkg::CSR_W'(text_attr_ff);
         tce_pkg::REG_BLANK_ATTR: prdata = tce_pkg::CSR_W'(blank_attr_ff);
         default:                 prdata = '0;
      endcase
   end

   assign cfg.text_attr  = text_attr_ff;
   assign cfg.blank_attr = blank_attr_ff;

   tce_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .status         (status),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   tce_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data)
   );

endmodule

// ===== src/tce_checker.sv =====
// ---------------------------------------------------------------------------
// tce_checker
// port-level checks of the text console engine, bound to the top level
// ---------------------------------------------------------------------------
module tce_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [tce_pkg::CURSOR_W-1:0]  rsp_cursor_pos,
   input logic [tce_pkg::DATA_W-1:0]    rsp_cell_data
);

   localparam int CELLS = COLUMNS * ROWS;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_pos)
         && $stable(rsp_cell_data))
      else $error("response changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // buffer blanking pass blocks requests after reset
   a_init_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted during buffer blanking");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_cursor_pos) < CELLS)
      else $error("cursor outside the screen");

endmodule

bind text_console_engine_unit tce_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tce_checker (.*);

// ===== test/text_console_engine_unit_tb.sv =====
// ---------------------------------------------------------------------------
// text_console_engine_unit_tb
// self-checking bench for the text console: a short directed sequence covers
// the reset screen, field extremes, cursor wrap cases, out-of-range reads and
// the unused function code, then random command words run under several
// attribute settings and handshake idling patterns. every reply is compared
// against a cycle-free model of the screen buffer and cursor kept in the bench.
// ---------------------------------------------------------------------------
module text_console_engine_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS        = 80;
   localparam int LINES       = 25;
   localparam int CELLS       = COLS * LINES;
   localparam int PHASES      = 6;
   localparam int PHASE_WORDS = 225;
   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int DIR_ROWS    = 23;

   localparam logic [tce_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [tce_pkg::FUNC_W-1:0]  func;
      logic [tce_pkg::CHAR_W-1:0]  ch;
      logic [tce_pkg::INDEX_W-1:0] idx;
   } cmd_word_type;

   typedef struct packed {
      logic [tce_pkg::CURSOR_W-1:0] cursor;
      logic [tce_pkg::DATA_W-1:0]   data;
   } reply_type;

   typedef struct packed {
      cmd_word_type                 cmd;
      logic                         known;
      logic [tce_pkg::CURSOR_W-1:0] cursor;
      logic [tce_pkg::DATA_W-1:0]   data;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic [tce_pkg::FUNC_W-1:0]    req_func       = '0;
   logic [tce_pkg::CHAR_W-1:0]    req_char_code  = '0;
   logic [tce_pkg::INDEX_W-1:0]   req_cell_index = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic [tce_pkg::CURSOR_W-1:0]  rsp_cursor_pos;
   logic [tce_pkg::DATA_W-1:0]    rsp_cell_data;
   logic                          psel           = 1'b0;
   logic                          penable        = 1'b0;
   logic                          pwrite         = 1'b0;
   logic [tce_pkg::PADDR_W-1:0]   paddr          = '0;
   logic [tce_pkg::CSR_W-1:0]     pwdata         = '0;
   logic [tce_pkg::CSR_W-1:0]     prdata;
   logic                          pready;

   // typed expectation travelling with the current word
   logic                          row_known  = 1'b0;
   logic [tce_pkg::CURSOR_W-1:0]  row_cursor = '0;
   logic [tce_pkg::DATA_W-1:0]    row_data   = '0;

   logic [tce_pkg::DATA_W-1:0]    screen [CELLS];
   int                            cur_col;
   int                            cur_row;
   logic [tce_pkg::ATTR_W-1:0]    attr_text;
   logic [tce_pkg::ATTR_W-1:0]    attr_blank;

   reply_type            due_replies [$];
   int                   mismatches  = 0;
   int                   cycle_count = 0;
   int                   send_idle   = 0;
   int                   stall_pct   = 0;

   dir_row_type directed_rows [DIR_ROWS] = '{
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd0},    1'b1, 11'd0,  16'h0F20},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd1999}, 1'b1, 11'd0,  16'h0F20},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd2000}, 1'b1, 11'd0,  16'h0000},
      '{'{tce_pkg::FUNC_READ,  8'hFF, 11'd2047}, 1'b1, 11'd0,  16'h0000},
      '{'{FUNC_UNUSED,         8'hFF, 11'd2047}, 1'b1, 11'd0,  16'h0000},
      '{'{tce_pkg::FUNC_PUT, tce_pkg::CHAR_BACKSPACE, 11'd0}, 1'b1, 11'd0, 16'h0000},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd0},    1'b1, 11'd0,  16'h0420},
      '{'{tce_pkg::FUNC_PUT,   8'hFF, 11'd2047}, 1'b1, 11'd1,  16'h0000},
      '{'{tce_pkg::FUNC_PUT,   8'h00, 11'd0},    1'b1, 11'd2,  16'h0000},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd0},    1'b1, 11'd2,  16'h04FF},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd1},    1'b1, 11'd2,  16'h0400},
      '{'{tce_pkg::FUNC_PUT, tce_pkg::CHAR_NEWLINE, 11'd0},   1'b1, 11'd80, 16'h0000},
      '{'{tce_pkg::FUNC_PUT, tce_pkg::CHAR_BACKSPACE, 11'd0}, 1'b1, 11'd79, 16'h0000},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd79},   1'b1, 11'd79, 16'h0420},
      '{'{tce_pkg::FUNC_PUT, tce_pkg::CHAR_TAB, 11'd0},       1'b1, 11'd87, 16'h0000},
      '{'{tce_pkg::FUNC_PUT, tce_pkg::CHAR_TAB, 11'd0},       1'b1, 11'd95, 16'h0000},
      '{'{tce_pkg::FUNC_PUT,   8'h41, 11'd0},    1'b1, 11'd96, 16'h0000},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd95},   1'b1, 11'd96, 16'h0441},
      '{'{tce_pkg::FUNC_PUT, tce_pkg::CHAR_BACKSPACE, 11'd0}, 1'b1, 11'd95, 16'h0000},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd95},   1'b1, 11'd95, 16'h0420},
      '{'{tce_pkg::FUNC_CLEAR, 8'h00, 11'd0},    1'b1, 11'd0,  16'h0000},
      '{'{tce_pkg::FUNC_READ,  8'h00, 11'd95},   1'b1, 11'd0,  16'h0F20},
      '{'{tce_pkg::FUNC_PUT, tce_pkg::CHAR_SPACE, 11'd0},     1'b0, 11'd0,  16'h0000}
   };

   text_console_engine_unit #(
      .COLUMNS (COLS),
      .ROWS    (LINES)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch %s at cycle %0d: got %0h want %0h", what, cycle_count, got, want);
   endtask

   // screen buffer and cursor after one command word
   function automatic reply_type console_step(input logic [tce_pkg::FUNC_W-1:0] fn,
                                              input logic [tce_pkg::CHAR_W-1:0] ch,
                                              input logic [tce_pkg::INDEX_W-1:0] idx);
      reply_type r;
      int        i;
      r.data = '0;
      case (fn)
         tce_pkg::FUNC_PUT: begin
            case (ch)
               tce_pkg::CHAR_BACKSPACE: begin
                  if (cur_col != 0) begin
                     cur_col--;
                  end else if (cur_row != 0) begin
                     cur_col = COLS - 1;
                     cur_row--;
                  end
                  screen[cur_row * COLS + cur_col] = {attr_text, tce_pkg::CHAR_SPACE};
               end
               tce_pkg::CHAR_TAB: begin
                  if (cur_col + tce_pkg::TAB_STEP >= COLS) begin
                     cur_col = cur_col + tce_pkg::TAB_STEP - COLS;
                     cur_row++;
                  end else begin
                     cur_col += tce_pkg::TAB_STEP;
                  end
               end
               tce_pkg::CHAR_NEWLINE: begin
                  cur_row++;
                  cur_col = 0;
               end
               default: begin
                  screen[cur_row * COLS + cur_col] = {attr_text, ch};
                  cur_col++;
               end
            endcase
            if (cur_col >= COLS) begin
               cur_col = 0;
               cur_row++;
            end
            // scroll up one line
            if (cur_row >= LINES) begin
               for (i = 0; i < COLS * (LINES - 1); i++) screen[i] = screen[i + COLS];
               for (i = COLS * (LINES - 1); i < CELLS; i++)
                  screen[i] = {attr_blank, tce_pkg::CHAR_SPACE};
               cur_col = 0;
               cur_row = LINES - 1;
            end
         end
         tce_pkg::FUNC_CLEAR: begin
            for (i = 0; i < CELLS; i++) screen[i] = {attr_blank, tce_pkg::CHAR_SPACE};
            cur_col = 0;
            cur_row = 0;
         end
         tce_pkg::FUNC_READ: begin
            if (idx < CELLS) r.data = screen[idx];
         end
         default: begin
         end
      endcase
      r.cursor = tce_pkg::CURSOR_W'(cur_row * COLS + cur_col);
      return r;
   endfunction

   function automatic cmd_word_type random_word();
      cmd_word_type w;
      int           pick;
      int           near;
      pick   = $urandom_range(999);
      near   = cur_row * COLS + cur_col - int'($urandom_range(160));
      w.func = tce_pkg::FUNC_PUT;
      w.ch   = tce_pkg::CHAR_W'($urandom_range(255));
      w.idx  = tce_pkg::INDEX_W'($urandom_range(2047));
      if (pick < 4) begin
         w.func = tce_pkg::FUNC_CLEAR;
      end else if (pick < 14) begin
         w.func = FUNC_UNUSED;
      end else if (pick < 214) begin
         w.func = tce_pkg::FUNC_READ;
         if (pick < 150) begin
            w.idx = tce_pkg::INDEX_W'((near < 0) ? 0 : near);
         end else if (pick < 200) begin
            w.idx = tce_pkg::INDEX_W'($urandom_range(CELLS - 1));
         end
      end else if (pick < 300) begin
         w.ch = tce_pkg::CHAR_NEWLINE;
      end else if (pick < 350) begin
         w.ch = tce_pkg::CHAR_TAB;
      end else if (pick < 410) begin
         w.ch = tce_pkg::CHAR_BACKSPACE;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      reply_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               report_mismatch("word with nothing due", 32'(rsp_cursor_pos), 32'd0);
            end else begin
               seen = due_replies.pop_front();
               if (rsp_cursor_pos !== seen.cursor)
                  report_mismatch("cursor_pos", 32'(rsp_cursor_pos), 32'(seen.cursor));
               if (rsp_cell_data !== seen.data)
                  report_mismatch("cell_data", 32'(rsp_cell_data), 32'(seen.data));
            end
         end
         if (req_valid && !req_stall) begin
            want = console_step(req_func, req_char_code, req_cell_index);
            if (row_known) begin
               want.cursor = row_cursor;
               want.data   = row_data;
            end
            due_replies.push_back(want);
         end
      end
   end

   task automatic send_word(input cmd_word_type w, input logic known,
                            input logic [tce_pkg::CURSOR_W-1:0] c,
                            input logic [tce_pkg::DATA_W-1:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= w.func;
      req_char_code  <= w.ch;
      req_cell_index <= w.idx;
      row_known      <= known;
      row_cursor     <= c;
      row_data       <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_attr(input logic which, input logic [tce_pkg::ATTR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= tce_pkg::PADDR_W'({which, 2'b00});
      pwdata  <= tce_pkg::CSR_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (which == tce_pkg::REG_TEXT_ATTR) attr_text = value;
      else attr_blank = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[tce_pkg::ATTR_W-1:0] !== value)
         report_mismatch("register readback", 32'(prdata), 32'(value));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int                         i;
      int                         ph;
      logic [tce_pkg::ATTR_W-1:0] t_attr;
      logic [tce_pkg::ATTR_W-1:0] b_attr;
      for (i = 0; i < CELLS; i++) screen[i] = tce_pkg::RESET_BLANK;
      cur_col    = 0;
      cur_row    = 0;
      attr_text  = tce_pkg::RESET_TEXT_ATTR;
      attr_blank = tce_pkg::RESET_BLANK_ATTR;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         send_word(directed_rows[i].cmd, directed_rows[i].known,
                   directed_rows[i].cursor, directed_rows[i].data);

      for (ph = 0; ph < PHASES; ph++) begin
         drain_replies();
         t_attr = tce_pkg::ATTR_W'($urandom_range(255));
         b_attr = tce_pkg::ATTR_W'($urandom_range(255));
         case (ph)
            0: begin
               t_attr = 8'h00;
               b_attr = 8'hFF;
            end
            1: begin
               t_attr = 8'hFF;
               b_attr = 8'h00;
            end
            3: begin
               t_attr = 8'h80;
               b_attr = 8'h7F;
            end
            default: begin
            end
         endcase
         write_attr(tce_pkg::REG_TEXT_ATTR, t_attr);
         write_attr(tce_pkg::REG_BLANK_ATTR, b_attr);
         case (ph % 4)
            0: begin
               send_idle = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle = 72;
               stall_pct = 0;
            end
            2: begin
               send_idle = 0;
               stall_pct = 72;
            end
            default: begin
               send_idle = 26;
               stall_pct = 26;
            end
         endcase
         repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0, '0);
      end

      drain_replies();
      stall_pct = 0;
      repeat (CELLS + 16) @(posedge clock);
      if (mismatches == 0 && due_replies.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
